/* design/tked_pkg.sv */
// tked_pkg: constants, types and the final-byte key lookup for the
// terminal key escape decoder. no dependencies.
`default_nettype none

package tked_pkg;

  localparam int unsigned PARAM_KEEP = 7;
  localparam int unsigned CNT_W      = $clog2(PARAM_KEEP + 1);

  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CSI  = 8'h5B;
  localparam logic [7:0] BYTE_SEMI = 8'h3B;
  localparam logic [7:0] BYTE_D0   = 8'h30;
  localparam logic [7:0] BYTE_D1   = 8'h31;
  localparam logic [7:0] BYTE_D2   = 8'h32;
  localparam logic [7:0] BYTE_D3   = 8'h33;
  localparam logic [7:0] BYTE_D4   = 8'h34;
  localparam logic [7:0] BYTE_D7   = 8'h37;
  localparam logic [7:0] BYTE_D8   = 8'h38;
  localparam logic [7:0] BYTE_D9   = 8'h39;
  localparam logic [7:0] FIN_UP    = 8'h41;
  localparam logic [7:0] FIN_DOWN  = 8'h42;
  localparam logic [7:0] FIN_RIGHT = 8'h43;
  localparam logic [7:0] FIN_LEFT  = 8'h44;
  localparam logic [7:0] FIN_HOME  = 8'h48;
  localparam logic [7:0] FIN_END   = 8'h46;
  localparam logic [7:0] FIN_TILDE = 8'h7E;

  localparam logic [7:0] KEY_NONE    = 8'h00;
  localparam logic [7:0] KEY_LEFT    = 8'hB4;
  localparam logic [7:0] KEY_UP      = 8'hB5;
  localparam logic [7:0] KEY_DOWN    = 8'hB6;
  localparam logic [7:0] KEY_RIGHT   = 8'hB7;
  localparam logic [7:0] KEY_S_LEFT  = 8'hB8;
  localparam logic [7:0] KEY_S_UP    = 8'hB9;
  localparam logic [7:0] KEY_S_DOWN  = 8'hBA;
  localparam logic [7:0] KEY_S_RIGHT = 8'hBB;
  localparam logic [7:0] KEY_HOME    = 8'hD2;
  localparam logic [7:0] KEY_DELETE  = 8'hD4;
  localparam logic [7:0] KEY_END     = 8'hD5;
  localparam logic [7:0] KEY_S_HOME  = 8'hD8;
  localparam logic [7:0] KEY_S_END   = 8'hD9;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SEMI_NONE = 2'd0,
    SEMI_LAST = 2'd1,
    SEMI_DONE = 2'd2
  } semi_e;

  function automatic logic [7:0] finish_key(logic [7:0] fin, logic [7:0] first, logic sh);
    logic [7:0] key;
    key = KEY_NONE;
    unique case (fin)
      FIN_UP:    key = sh ? KEY_S_UP    : KEY_UP;
      FIN_DOWN:  key = sh ? KEY_S_DOWN  : KEY_DOWN;
      FIN_RIGHT: key = sh ? KEY_S_RIGHT : KEY_RIGHT;
      FIN_LEFT:  key = sh ? KEY_S_LEFT  : KEY_LEFT;
      FIN_HOME:  key = sh ? KEY_S_HOME  : KEY_HOME;
      FIN_END:   key = sh ? KEY_S_END   : KEY_END;
      FIN_TILDE: begin
        if (first == BYTE_D3) key = KEY_DELETE;
        else if (first == BYTE_D1 || first == BYTE_D7) key = sh ? KEY_S_HOME : KEY_HOME;
        else if (first == BYTE_D4 || first == BYTE_D8) key = sh ? KEY_S_END : KEY_END;
        else key = KEY_NONE;
      end
      default:   key = KEY_NONE;
    endcase
    return key;
  endfunction

endpackage

`default_nettype wire

/* design/tked_stream_if.sv */
// tked_in_if and tked_out_if: valid/ready byte channels for the decoder.
// no dependencies.
`default_nettype none

interface tked_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tked_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

/* design/terminal_key_escape_decoder.sv */
// terminal_key_escape_decoder: byte stream to key codes, CSI sequence decode.
// the key code is registered: the input transaction loads the input register, then
// the decode loads the result register. throughput one byte per cycle, set by the
// single decode stage. stalls only when the result register is held and the byte
// in the input register would give a key.
// reset clears all decoder state. depends on tked_pkg, tked_in_if, tked_out_if.
`default_nettype none

module terminal_key_escape_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tked_in_if.sink   in_ch,
  tked_out_if.source out_ch
);
  import tked_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_byte_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       key_q;

  logic             after_return_q, after_return_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       first_q, first_d;
  semi_e            semi_q, semi_d;
  logic             shift_q, shift_d;

  logic             res;
  logic [7:0]       key_d;
  logic             is_param;
  logic             s1_adv, s1_fire, in_fire;

  always_comb begin
    after_return_d = after_return_q;
    phase_d        = phase_q;
    count_d        = count_q;
    first_d        = first_q;
    semi_d         = semi_q;
    shift_d        = shift_q;
    res            = 1'b0;
    key_d          = KEY_NONE;
    is_param       = ((s1_byte_q >= BYTE_D0) && (s1_byte_q <= BYTE_D9)) ||
                     (s1_byte_q == BYTE_SEMI);
    unique case (phase_q)
      PH_ESC: begin
        if (s1_byte_q == BYTE_CSI) begin
          phase_d = PH_CSI;
          count_d = '0;
          first_d = KEY_NONE;
          semi_d  = SEMI_NONE;
          shift_d = 1'b0;
        end else begin
          phase_d = PH_IDLE;
          res     = 1'b1;
        end
      end
      PH_CSI: begin
        if (is_param) begin
          if (count_q < CNT_W'(PARAM_KEEP)) begin
            if (count_q == '0) first_d = s1_byte_q;
            if (semi_q == SEMI_LAST) begin
              shift_d = (s1_byte_q == BYTE_D2);
              semi_d  = SEMI_DONE;
            end else if (semi_q == SEMI_NONE && s1_byte_q == BYTE_SEMI) begin
              semi_d = SEMI_LAST;
            end
            count_d = count_q + 1'b1;
          end
        end else begin
          phase_d = PH_IDLE;
          res     = 1'b1;
          key_d   = finish_key(s1_byte_q, first_q, shift_q);
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (s1_byte_q == BYTE_LF && after_return_q) begin
          after_return_d = 1'b0;
        end else begin
          after_return_d = (s1_byte_q == BYTE_CR);
          if (s1_byte_q == BYTE_ESC) begin
            phase_d = PH_ESC;
          end else begin
            res   = 1'b1;
            key_d = s1_byte_q;
          end
        end
      end
    endcase
  end

  assign s1_adv       = !out_valid_q || out_ch.ready || !res;
  assign s1_fire      = s1_valid_q && s1_adv;
  assign in_ch.ready  = !s1_valid_q || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_q;
  assign out_ch.key_code = key_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_fire && res) out_valid_d = 1'b1;
    else if (out_ch.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      after_return_q <= 1'b0;
      phase_q        <= PH_IDLE;
      count_q        <= '0;
      first_q        <= KEY_NONE;
      semi_q         <= SEMI_NONE;
      shift_q        <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        after_return_q <= after_return_d;
        phase_q        <= phase_d;
        count_q        <= count_d;
        first_q        <= first_d;
        semi_q         <= semi_d;
        shift_q        <= shift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_byte_q <= in_ch.in_byte;
    if (s1_fire && res) key_q <= key_d;
  end

endmodule

`default_nettype wire

/* design/tked_checker.sv */
// tked_checker: port-level checks for terminal_key_escape_decoder, bound in below.
// depends on terminal_key_escape_decoder and its channel interfaces.
`default_nettype none

module tked_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] key_code_i
);

  // stalled result holds its key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_code_i))
    else $error("stalled key code changed");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a key in an empty result register needs an input transaction through the input register first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("key code without earlier input transaction");

endmodule

bind terminal_key_escape_decoder tked_checker u_tked_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .key_code_i  (out_ch.key_code)
);

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for terminal_key_escape_decoder, with directed byte table,
// random escape sequences, random idling on both channels and a long receiver hold-off.
// depends on tked_pkg, tked_in_if, tked_out_if and the decoder rtl.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tked_pkg::*;

  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_N      = 150;
  localparam int RAND_ITEMS  = 1400;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    logic [7:0] key;
  } feed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tked_in_if  in_ch ();
  tked_out_if out_ch ();

  terminal_key_escape_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // decoder state as predicted
  phase_e     ph        = PH_IDLE;
  semi_e      semi_st   = SEMI_NONE;
  bit         cr_seen   = 1'b0;
  int         kept_cnt  = 0;
  logic [7:0] first_char = 8'h00;
  bit         shifted   = 1'b0;

  logic [7:0] key_q [$];
  feed_t      feed_q [$];
  int         errors    = 0;
  bit         hold_req  = 1'b0;
  bit         tail_mode = 1'b0;

  feed_t dir_tab [28] = '{
    '{8'h00, 1'b1, KEY_NONE}, '{8'hFF, 1'b1, 8'hFF}, '{BYTE_CR, 1'b1, BYTE_CR},
    '{BYTE_LF, 1'b0, 8'h00}, '{BYTE_LF, 1'b1, BYTE_LF},
    '{BYTE_ESC, 1'b0, 8'h00}, '{FIN_UP, 1'b1, KEY_NONE},
    '{BYTE_ESC, 1'b0, 8'h00}, '{BYTE_CSI, 1'b0, 8'h00}, '{BYTE_D1, 1'b0, 8'h00},
    '{BYTE_SEMI, 1'b0, 8'h00}, '{BYTE_D2, 1'b0, 8'h00}, '{FIN_HOME, 1'b0, 8'h00},
    '{BYTE_ESC, 1'b0, 8'h00}, '{BYTE_CSI, 1'b0, 8'h00}, '{BYTE_D3, 1'b0, 8'h00},
    '{FIN_TILDE, 1'b0, 8'h00},
    '{BYTE_ESC, 1'b0, 8'h00}, '{BYTE_CSI, 1'b0, 8'h00}, '{BYTE_D1, 1'b0, 8'h00},
    '{BYTE_D2, 1'b0, 8'h00}, '{BYTE_D3, 1'b0, 8'h00}, '{BYTE_D4, 1'b0, 8'h00},
    '{8'h35, 1'b0, 8'h00}, '{8'h36, 1'b0, 8'h00}, '{BYTE_SEMI, 1'b0, 8'h00},
    '{BYTE_D2, 1'b0, 8'h00}, '{FIN_UP, 1'b0, 8'h00}
  };

  logic [7:0] fin_set [7] = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT, FIN_HOME, FIN_END,
                              FIN_TILDE};
  logic [7:0] lead_set [6] = '{BYTE_D1, BYTE_D3, BYTE_D4, BYTE_D7, BYTE_D8, BYTE_SEMI};

  function automatic bit is_param(logic [7:0] b);
    return (b >= BYTE_D0 && b <= BYTE_D9) || b == BYTE_SEMI;
  endfunction

  function automatic logic [7:0] csi_key(logic [7:0] fin);
    logic [7:0] plain;
    logic [7:0] alt;
    plain = KEY_NONE;
    alt   = KEY_NONE;
    if (fin == FIN_UP) begin
      plain = KEY_UP;    alt = KEY_S_UP;
    end else if (fin == FIN_DOWN) begin
      plain = KEY_DOWN;  alt = KEY_S_DOWN;
    end else if (fin == FIN_RIGHT) begin
      plain = KEY_RIGHT; alt = KEY_S_RIGHT;
    end else if (fin == FIN_LEFT) begin
      plain = KEY_LEFT;  alt = KEY_S_LEFT;
    end else if (fin == FIN_HOME) begin
      plain = KEY_HOME;  alt = KEY_S_HOME;
    end else if (fin == FIN_END) begin
      plain = KEY_END;   alt = KEY_S_END;
    end else if (fin == FIN_TILDE) begin
      if (first_char == BYTE_D3) begin
        plain = KEY_DELETE; alt = KEY_DELETE;
      end else if (first_char == BYTE_D1 || first_char == BYTE_D7) begin
        plain = KEY_HOME;   alt = KEY_S_HOME;
      end else if (first_char == BYTE_D4 || first_char == BYTE_D8) begin
        plain = KEY_END;    alt = KEY_S_END;
      end
    end
    return shifted ? alt : plain;
  endfunction

  task automatic decode_byte(input logic [7:0] b, output bit got, output logic [7:0] key);
    got = 1'b1;
    key = b;
    case (ph)
      PH_ESC: begin
        if (b == BYTE_CSI) begin
          ph         = PH_CSI;
          kept_cnt   = 0;
          first_char = 8'h00;
          semi_st    = SEMI_NONE;
          shifted    = 1'b0;
          got        = 1'b0;
        end else begin
          ph  = PH_IDLE;
          key = KEY_NONE;
        end
      end
      PH_CSI: begin
        if (is_param(b)) begin
          got = 1'b0;
          if (kept_cnt < PARAM_KEEP) begin
            if (kept_cnt == 0) first_char = b;
            if (semi_st == SEMI_LAST) begin
              shifted = (b == BYTE_D2);
              semi_st = SEMI_DONE;
            end else if (semi_st == SEMI_NONE && b == BYTE_SEMI) begin
              semi_st = SEMI_LAST;
            end
            kept_cnt++;
          end
        end else begin
          ph  = PH_IDLE;
          key = csi_key(b);
        end
      end
      default: begin
        ph = PH_IDLE;
        if (b == BYTE_LF && cr_seen) begin
          cr_seen = 1'b0;
          got     = 1'b0;
        end else begin
          cr_seen = (b == BYTE_CR);
          if (b == BYTE_ESC) begin
            ph  = PH_ESC;
            got = 1'b0;
          end
        end
      end
    endcase
  endtask

  function automatic void add(logic [7:0] b);
    feed_t it;
    it.b     = b;
    it.typed = 1'b0;
    it.key   = 8'h00;
    feed_q.push_back(it);
  endfunction

  // mostly well-formed csi sequences, then esc errors, line endings and noise
  task automatic add_random_chunk();
    int         r;
    int         n;
    logic [7:0] c;
    logic [7:0] prev;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      add(BYTE_ESC);
      add(BYTE_CSI);
      n    = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      prev = 8'h00;
      for (int j = 0; j < n; j++) begin
        if (j == 0 && $urandom_range(0, 3) != 0) c = lead_set[$urandom_range(0, 5)];
        else if (prev == BYTE_SEMI && $urandom_range(0, 1) == 0) c = BYTE_D2;
        else if ($urandom_range(0, 3) == 0) c = BYTE_SEMI;
        else c = BYTE_D0 + 8'($urandom_range(0, 9));
        add(c);
        prev = c;
      end
      if ($urandom_range(0, 9) < 8) begin
        add(fin_set[$urandom_range(0, 6)]);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (is_param(c));
        add(c);
      end
    end else if (r < 65) begin
      add(BYTE_ESC);
      add(8'($urandom_range(0, 255)));
    end else if (r < 75) begin
      add(BYTE_CR);
      if ($urandom_range(0, 9) < 7) add(BYTE_LF);
      if ($urandom_range(0, 2) == 0) add(BYTE_LF);
    end else begin
      add(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : feeder
    feed_t      it;
    bit         got;
    bit         calm;
    logic [7:0] pk;
    int         idx;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    foreach (dir_tab[i]) feed_q.push_back(dir_tab[i]);
    while (feed_q.size() < $size(dir_tab) + RAND_ITEMS) add_random_chunk();
    wait (rst_ni);
    @(posedge clk_i);
    idx = 0;
    while (feed_q.size() != 0) begin
      it        = feed_q.pop_front();
      tail_mode = feed_q.size() < TAIL_N;
      calm      = tail_mode || (idx >= HOLD_AT && idx < HOLD_AT + 120);
      if (idx == HOLD_AT) hold_req = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= it.b;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      decode_byte(it.b, got, pk);
      if (got || it.typed) key_q.push_back(it.typed ? it.key : pk);
      idx++;
    end
    in_ch.valid <= 1'b0;
    while (key_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : receiver
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!tail_mode && $urandom_range(0, 9) < 3) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (key_q.size() == 0) begin
        $display("%0t: key_code %02h arrived, expected none", $time, out_ch.key_code);
        errors++;
      end else begin
        want = key_q.pop_front();
        if (out_ch.key_code !== want) begin
          $display("%0t: key_code mismatch, expected %02h, actual %02h",
                   $time, want, out_ch.key_code);
          errors++;
        end
      end
    end
  end

endmodule

`default_nettype wire
